// ----- rtl/sdaf_pkg.sv -----
`default_nettype none

package sdaf_pkg;

  // Longest decimal rendering of a 32-bit magnitude.
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CHAR_W     = 8;

  // floor(x / 10) == (x * RECIP_TEN) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [DATA_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned       RECIP_SHIFT = 35;
  localparam int unsigned       QUOT_W      = 2 * DATA_W - RECIP_SHIFT;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    SEL_SIGN,
    SEL_DIGIT,
    SEL_CR,
    SEL_LF
  } char_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      load_in;
    logic      mul;
    logic      div;
    logic      emit;
    char_sel_e sel;
    logic      last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic quot_zero;
    logic cnt_zero;
    logic cnt_one;
    logic negative;
    logic line_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/sdaf_dp.sv -----
`default_nettype none

module sdaf_dp
  import sdaf_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire logic signed [31:0] number_i,
  input  wire logic               add_line_end_i,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [CHAR_W-1:0]       character_o,
  output logic                    last_char_o
);

  logic [DATA_W-1:0]  quot_q, quot_d;
  logic [QUOT_W-1:0]  prod_q;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               neg_q, line_end_q;
  logic [DIGIT_W-1:0] store_q [MAX_DIGITS];
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q;

  logic [2*DATA_W-1:0] product;
  logic [DATA_W-1:0]   quot_next, times_ten, remainder, magnitude;
  logic [DIGIT_W-1:0]  rd_digit;
  logic [CNT_W-1:0]    rd_idx;

  assign magnitude = number_i[31] ? (DATA_W'(0) - DATA_W'(number_i)) : DATA_W'(number_i);

  // Reciprocal multiply, registered before the remainder is formed.
  assign product   = {{DATA_W{1'b0}}, quot_q} * {{DATA_W{1'b0}}, RECIP_TEN};
  assign quot_next = DATA_W'(prod_q);
  assign times_ten = (quot_next << 3) + (quot_next << 1);
  assign remainder = quot_q - times_ten;

  assign rd_idx   = cnt_q - CNT_W'(1);
  assign rd_digit = store_q[rd_idx];

  always_comb begin
    quot_d = quot_q;
    cnt_d  = cnt_q;
    if (cmd_i.load_in) begin
      quot_d = magnitude;
      cnt_d  = '0;
    end else if (cmd_i.div) begin
      quot_d = quot_next;
      cnt_d  = cnt_q + CNT_W'(1);
    end else if (cmd_i.emit && (cmd_i.sel == SEL_DIGIT)) begin
      cnt_d = rd_idx;
    end
  end

  always_comb begin
    unique case (cmd_i.sel)
      SEL_SIGN:  char_d = CH_MINUS;
      SEL_DIGIT: char_d = CH_ZERO + CHAR_W'(rd_digit);
      SEL_CR:    char_d = CH_CR;
      SEL_LF:    char_d = CH_LF;
      default:   char_d = CH_LF;
    endcase
  end

  always_comb begin
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      quot_q      <= quot_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      neg_q      <= number_i[31];
      line_end_q <= add_line_end_i;
    end
    if (cmd_i.mul) begin
      prod_q <= product[2*DATA_W-1:RECIP_SHIFT];
    end
    if (cmd_i.div) begin
      store_q[cnt_q] <= remainder[DIGIT_W-1:0];
    end
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= cmd_i.last;
    end
  end

  always_comb begin
    sts_o.quot_zero = (quot_q == '0);
    sts_o.cnt_zero  = (cnt_q == '0);
    sts_o.cnt_one   = (cnt_q == CNT_W'(1));
    sts_o.negative  = neg_q;
    sts_o.line_end  = line_end_q;
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

// ----- rtl/sdaf_ctrl.sv -----
`default_nettype none

module sdaf_ctrl
  import sdaf_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire sts_t  sts_i,
  output cmd_t       cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;
  localparam logic [2:0] ST_CR    = 3'd5;
  localparam logic [2:0] ST_LF    = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] first_emit;

  // Where the output phase starts once all digits are stored.
  always_comb begin
    if (sts_i.negative) begin
      first_emit = ST_SIGN;
    end else if (!sts_i.cnt_zero) begin
      first_emit = ST_DIGIT;
    end else if (sts_i.line_end) begin
      first_emit = ST_CR;
    end else begin
      first_emit = ST_IDLE;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.sel     = SEL_SIGN;
    in_stall_o    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts_i.quot_zero) begin
          state_d = first_emit;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_MUL;
      end
      ST_SIGN: begin
        cmd_o.sel  = SEL_SIGN;
        cmd_o.last = sts_i.cnt_zero && !sts_i.line_end;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.cnt_zero) begin
            state_d = ST_DIGIT;
          end else if (sts_i.line_end) begin
            state_d = ST_CR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIGIT: begin
        cmd_o.sel  = SEL_DIGIT;
        cmd_o.last = sts_i.cnt_one && !sts_i.line_end;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!sts_i.cnt_one) begin
            state_d = ST_DIGIT;
          end else if (sts_i.line_end) begin
            state_d = ST_CR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CR: begin
        cmd_o.sel = SEL_CR;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_LF;
        end
      end
      ST_LF: begin
        cmd_o.sel  = SEL_LF;
        cmd_o.last = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/signed_decimal_ascii_formatter.sv -----
`default_nettype none

// Renders a signed 32-bit number as ASCII decimal text, one character per
// output transfer: a minus sign for negative values, then the digits most
// significant first with no leading zeros, then carriage return and line feed
// when add_line_end_i is set; last_char_o marks the final character of each
// run. A value of zero yields no digits, so zero without a line end yields no
// output at all. Digits are extracted least significant first by a reciprocal
// multiplier: each digit takes an ST_MUL step for the 32 by 32 multiply and an
// ST_DIV step for the remainder and store, and a final ST_MUL step sees the
// quotient reach zero. The next item is taken as soon as the final character
// has been loaded into the output register, so it is accepted while that
// character still waits for its transfer.

module signed_decimal_ascii_formatter
  import sdaf_pkg::*;
(
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] number_i,
  input  wire logic               add_line_end_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [7:0]              character_o,
  output logic                    last_char_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller sequences extraction and emission; of the datapath it sees only status.
  sdaf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the quotient, digit store and the output register.
  sdaf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .number_i       (number_i),
    .add_line_end_i (add_line_end_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .character_o    (character_o),
    .last_char_o    (last_char_o)
  );

  // Whenever the block is ready for a new item, every stored digit has left.
  a_idle_no_digits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> sts.cnt_zero)
    else $error("digits left over when a new item may enter");

  // An accepted item always keeps the block busy in the following cycle.
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block ready again straight after an accepted item");

  // A character is only loaded when the output register can take it.
  a_emit_into_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("output register overwritten before its transfer");

  // Only the minus sign, a decimal digit, carriage return or line feed leave.
  a_char_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((character_o >= CH_ZERO && character_o <= 8'h39) ||
                     character_o == CH_MINUS || character_o == CH_CR ||
                     character_o == CH_LF))
    else $error("unexpected character on the output");

endmodule

`default_nettype wire

// ----- bench/decimal_text_checker.sv -----
`default_nettype none

// Watches both channels of the formatter. It predicts the character run
// for every accepted number and compares each output transfer with the
// oldest character still due.
module decimal_text_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [31:0] number_i,
  input  wire logic        add_line_end_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [7:0]  character_i,
  input  wire logic        last_char_i,
  output int               mismatch_count_o,
  output int               chars_due_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_LF    = 8'h0A;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  text_char_t chars_due[$];
  text_char_t oldest;
  int         mismatches;

  function automatic text_char_t plain_char(input logic [7:0] code);
    text_char_t entry;
    entry.ch   = code;
    entry.last = 1'b0;
    return entry;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t ns: mismatch: %s", $realtime, what);
  endtask

  // The run is a sign for a negative value, the digits of the magnitude most
  // significant first, then CR and LF if asked for; the final character of the run is marked.
  task automatic predict_decimal_text(input logic [31:0] value, input logic line_end);
    logic [31:0] magnitude;
    logic [3:0]  digit_buf [0:9];
    int          n_digits;
    text_char_t  run[$];
    text_char_t  entry;
    magnitude = value[31] ? (32'd0 - value) : value;
    n_digits  = 0;
    if (value[31]) run.push_back(plain_char(ASCII_MINUS));
    while (magnitude != 32'd0) begin
      digit_buf[n_digits] = 4'(magnitude % 32'd10);
      magnitude           = magnitude / 32'd10;
      n_digits++;
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      run.push_back(plain_char(ASCII_ZERO + {4'd0, digit_buf[i]}));
    end
    if (line_end) begin
      run.push_back(plain_char(ASCII_CR));
      run.push_back(plain_char(ASCII_LF));
    end
    for (int i = 0; i < run.size(); i++) begin
      entry      = run[i];
      entry.last = (i == run.size() - 1);
      chars_due.push_back(entry);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_due.delete();
      mismatches       = 0;
      mismatch_count_o <= 0;
      chars_due_o      <= 0;
    end else begin
      // Output first: a character leaving now cannot belong to a number
      // that is taken in at this same edge.
      if (out_valid_i && !out_stall_i) begin
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("character 0x%02h with none due", character_i));
        end else begin
          oldest = chars_due.pop_front();
          if (character_i !== oldest.ch) begin
            report_mismatch($sformatf("character 0x%02h, wanted 0x%02h",
                                      character_i, oldest.ch));
          end
          if (last_char_i !== oldest.last) begin
            report_mismatch($sformatf("last_char %b, wanted %b (character 0x%02h)",
                                      last_char_i, oldest.last, oldest.ch));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        predict_decimal_text(number_i, add_line_end_i);
      end
      mismatch_count_o <= mismatches;
      chars_due_o      <= chars_due.size();
    end
  end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none

// Top of the bench for the signed decimal formatter. It drives numbers into
// the block, plays the part of the character receiver and gives the verdict.
// All prediction and comparison lives in the checker instantiated beside the
// block; this module only makes stimulus and decides when the run is over.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Quiet cycles tolerated before the run is declared hung. It must exceed
  // the deliberate receiver hold-off below by a wide margin, as well as the
  // longest natural gap.
  localparam int WATCHDOG_LIMIT = 2000;
  // Length of the long receiver hold-off that fills the block up.
  localparam int HOLD_CYCLES    = 300;
  // Cycles allowed after the last character has arrived, so that a stray
  // extra transfer would still be seen.
  localparam int SETTLE_CYCLES  = 64;
  localparam int ITEMS_PER_PHASE = 80;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic signed [31:0] number_i      = '0;
  logic              add_line_end_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [7:0]        character_o;
  logic              last_char_o;

  int mismatch_count;
  int chars_due;
  int idle_cycles = 0;

  // Idling settings of the current phase, in percent of cycles.
  int  sender_idle_pct   = 0;
  int  receiver_stall_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit  long_hold_req     = 1'b0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  signed_decimal_ascii_formatter DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .number_i       (number_i),
    .add_line_end_i (add_line_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .character_o    (character_o),
    .last_char_o    (last_char_o)
  );

  decimal_text_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_i       (in_stall_o),
    .number_i         (number_i),
    .add_line_end_i   (add_line_end_i),
    .out_valid_i      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .character_i      (character_o),
    .last_char_i      (last_char_o),
    .mismatch_count_o (mismatch_count),
    .chars_due_o      (chars_due)
  );

  // Offers one number and returns at the edge where the transfer happens.
  // Idle cycles are inserted before the offer only, so valid never depends
  // on the stall and an offered number is held steady until it is taken.
  // Each call assigns in_valid_i at most once per time step.
  task automatic send_number(input logic [31:0] value, input logic line_end);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    number_i       <= value;
    add_line_end_i <= line_end;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
  endtask

  function automatic logic [63:0] power_of_ten(input int exponent);
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = 0; i < exponent; i++) acc = acc * 64'd10;
    return acc;
  endfunction

  // Random numbers are spread over all digit counts rather than left to a
  // flat 32-bit draw, which would give ten digits in over half of all draws.
  // A share of draws lands on either side of a power of ten, where the digit
  // count changes, and a few are zero or fully random bit patterns.
  function automatic logic [31:0] random_number();
    logic [63:0] magnitude;
    logic [31:0] value;
    int          kind;
    kind = $urandom_range(9);
    case (kind)
      0: begin
        return $urandom();
      end
      1: begin
        magnitude = $urandom_range(9);
      end
      2: begin
        magnitude = power_of_ten($urandom_range(1, 9)) + $urandom_range(2) - 1;
      end
      default: begin
        magnitude = {32'd0, $urandom()} % power_of_ten($urandom_range(1, 10));
      end
    endcase
    value = magnitude[31:0];
    if ($urandom_range(1)) value = 32'd0 - value;
    return value;
  endfunction

  // The receiver. Normally it stalls at random at the phase's rate; when a
  // long hold-off is asked for it keeps the stall high for HOLD_CYCLES while
  // the sender carries on, so the block fills and stalls its own input in
  // turn.
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // Watchdog: any cycle with a transfer on either channel resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed numbers: zero with and without a line end (the latter gives
    // no characters at all), single digits, the step from one digit count
    // to the next, both ends of the signed range including the most
    // negative value whose magnitude only fits unsigned, and the longest
    // runs with a sign, ten digits and a line end.
    send_number(32'sd0, 1'b0);
    send_number(32'sd0, 1'b1);
    send_number(32'sd1, 1'b0);
    send_number(-32'sd1, 1'b1);
    send_number(32'sd9, 1'b1);
    send_number(32'sd10, 1'b0);
    send_number(-32'sd10, 1'b0);
    send_number(32'sd99, 1'b1);
    send_number(32'sd100, 1'b0);
    send_number(-32'sd5, 1'b1);
    send_number(32'sd0, 1'b0);
    send_number(32'sd0, 1'b0);
    send_number(32'sd999999999, 1'b0);
    send_number(32'sd1000000000, 1'b1);
    send_number(32'sd123456789, 1'b1);
    send_number(32'sh7FFFFFFF, 1'b0);
    send_number(32'sh7FFFFFFF, 1'b1);
    send_number(32'sh80000000, 1'b0);
    send_number(32'sh80000000, 1'b1);
    send_number(32'sh80000001, 1'b1);
    send_number(-32'sd1000000000, 1'b0);
    send_number(32'sh55555555, 1'b0);
    send_number(32'shAAAAAAAA, 1'b1);

    // Random phases: no idling, a slow sender, a slow receiver, then both.
    // The first phase opens with the long receiver hold-off.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          long_hold_req      = 1'b1;
        end
        1: begin
          sender_idle_pct    = 58;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 58;
        end
        default: begin
          sender_idle_pct    = 30;
          receiver_stall_pct = 30;
        end
      endcase
      repeat (ITEMS_PER_PHASE) send_number(random_number(), $urandom_range(1));
    end
    in_valid_i <= 1'b0;
    // The checker's count of due characters is a register updated at the edge,
    // so the final number is not yet in it when its transfer completes.
    @(posedge clk_i);

    // Let every predicted character arrive; the watchdog bounds this wait.
    while (chars_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && chars_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/sdaf_pkg.sv
rtl/sdaf_dp.sv
rtl/sdaf_ctrl.sv
rtl/signed_decimal_ascii_formatter.sv
bench/decimal_text_checker.sv
bench/testbench.sv
